[hdl/assert_macros.svh]
// Assertion macros used by the RTL of the debouncer.
// No dependencies; included by the top level, which carries the checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_HOLDS(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

[hdl/mpde_pkg.sv]
// Types and constants of the multi-pin edge debouncer.
// No dependencies; used by the top level.
package mpde_pkg;

  localparam int unsigned PIN_COUNT_DEF  = 8;
  localparam int unsigned TIMER_BITS_DEF = 8;
  localparam logic [7:0]  LOCKOUT_RESET  = 8'd20;

  typedef enum logic [1:0] {
    OP_DC     = 2'd0,
    OP_AC_NOW = 2'd1,
    OP_AC_END = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [2:0] pin_index;
    logic       level;
    logic       trigger_level;
  } in_t;

  typedef struct packed {
    logic       event_fired;
    logic [2:0] event_pin;
    logic       event_edge;
  } out_t;

endpackage

[hdl/mpde_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used by the top level for the per-pin state.
module mpde_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/multi_pin_edge_debouncer_unit.sv]
// Top level of the multi-pin edge debouncer.
// Depends on mpde_pkg, mpde_ram and assert_macros.svh.
//
// Usage: every input transaction is one sample tick of one pin, carrying the
// mode, the pin index, the sampled level and the trigger level. Each input
// transaction produces exactly one output transaction telling whether the
// tick fired the key event, together with the pin and edge held in the
// event buffer after the tick. Both channels use valid and stall.
// The lockout length is written through cfg_we_i and cfg_data_i; the user
// must write it only while the block is idle (not enforced by the block);
// it takes effect for the next sample. Samples pass stage 1 (RAM read) and
// the output register. The block accepts one transaction per clock while
// the receiver does not stall: the per-pin timer and last level live in a
// small RAM with registered read data, read when the sample is accepted
// and written back as it leaves stage 1. A write-back register forwards the
// newest entry to a sample of the same pin that follows directly.
// When the receiver stalls, the output register holds its transaction and
// the stage behind it holds too; only then does the input see a stall.
// Reset clears per-pin valid flags (an entry never written reads as zero),
// the event buffer, the pipeline and sets the lockout length to 20 ticks.
`include "assert_macros.svh"

module multi_pin_edge_debouncer_unit
  import mpde_pkg::*;
#(
  parameter int unsigned PIN_COUNT  = PIN_COUNT_DEF,
  parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_t       out_data_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i
);

  localparam int unsigned AW = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
  localparam int unsigned EW = TIMER_BITS + 1;

  // One RAM entry: lockout timer and the last tracked level of the pin.
  typedef struct packed {
    logic [TIMER_BITS-1:0] timer;
    logic                  prev;
  } entry_t;

  logic [7:0]           lockout_q;
  logic [PIN_COUNT-1:0] pin_valid_q;

  // Stage 1: sample waiting on its RAM read.
  logic          s1_valid_q;
  in_t           s1_data_q;
  logic          s1_act_q;
  logic          s1_pvld_q;
  logic          s1_hold;
  logic          s1_go;
  logic [AW-1:0] s1_addr;

  // Write-back bypass.
  logic          wb_valid_q;
  logic [AW-1:0] wb_addr_q;
  entry_t        wb_data_q;

  logic [2:0] buf_pin_q, buf_pin_d;
  logic       buf_edge_q, buf_edge_d;

  logic out_valid_q;
  out_t out_q;

  logic          in_accept;
  logic          in_act;
  logic [AW-1:0] in_addr;
  logic [EW-1:0] ram_rdata;
  entry_t        cur, nxt;
  logic          fired;
  logic          ram_we;
  logic [TIMER_BITS-1:0] reload;
  logic [TIMER_BITS-1:0] t_dec;
  logic          trig_edge;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lockout_q <= LOCKOUT_RESET;
    end else if (cfg_we_i) begin
      lockout_q <= cfg_data_i;
    end
  end

  assign reload = TIMER_BITS'(lockout_q);

  // ---------------------------------------------------------------------------
  // Input side and RAM read
  // ---------------------------------------------------------------------------
  assign s1_hold    = out_valid_q && out_stall_i;
  assign s1_go      = s1_valid_q && !s1_hold;
  assign in_stall_o = s1_valid_q && s1_hold;
  assign in_accept  = in_valid_i && !in_stall_o;

  // An unused mode or a pin beyond the configured count touches no state.
  assign in_act  = ((in_data_i.operation == OP_DC) ||
                    (in_data_i.operation == OP_AC_NOW) ||
                    (in_data_i.operation == OP_AC_END)) &&
                   (int'(in_data_i.pin_index) < int'(PIN_COUNT));
  assign in_addr = AW'(in_data_i.pin_index);
  assign s1_addr = AW'(s1_data_q.pin_index);

  mpde_ram #(
    .WIDTH (EW),
    .DEPTH (PIN_COUNT)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr),
    .wdata_i (nxt),
    .re_i    (in_accept && in_act),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_data_q <= in_data_i;
      s1_act_q  <= in_act;
      s1_pvld_q <= pin_valid_q[in_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: modify and write back
  // ---------------------------------------------------------------------------
  always_comb begin
    // The bypass always holds the newest value of its pin.
    if (wb_valid_q && (wb_addr_q == s1_addr)) begin
      cur = wb_data_q;
    end else if (s1_pvld_q) begin
      cur = entry_t'(ram_rdata);
    end else begin
      cur = '0;
    end
  end

  assign trig_edge = (s1_data_q.level == s1_data_q.trigger_level) &&
                     (cur.prev != s1_data_q.trigger_level);
  assign t_dec     = cur.timer - TIMER_BITS'(1);

  always_comb begin
    nxt        = cur;
    fired      = 1'b0;
    buf_pin_d  = buf_pin_q;
    buf_edge_d = buf_edge_q;
    case (s1_data_q.operation)
      OP_DC: begin
        if (cur.timer != '0) begin
          // Lockout: count down, the pin is not tracked.
          nxt.timer = t_dec;
        end else begin
          if (s1_data_q.level != cur.prev) begin
            fired      = 1'b1;
            buf_edge_d = s1_data_q.level;
            buf_pin_d  = s1_data_q.pin_index;
            nxt.timer  = reload;
          end
          nxt.prev = s1_data_q.level;
        end
      end
      default: begin
        // Both AC modes; an edge inside the lockout restarts it.
        if (cur.timer != '0) begin
          if ((s1_data_q.operation == OP_AC_END) && (t_dec == '0)) begin
            fired = 1'b1;
          end
          nxt.timer = trig_edge ? reload : t_dec;
        end else if (trig_edge) begin
          nxt.timer = reload;
          buf_pin_d = s1_data_q.pin_index;
          if (s1_data_q.operation == OP_AC_NOW) begin
            fired = 1'b1;
          end
        end
        nxt.prev = s1_data_q.level;
      end
    endcase
  end

  assign ram_we = s1_go && s1_act_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_valid_q <= '0;
      wb_valid_q  <= 1'b0;
      buf_pin_q   <= '0;
      buf_edge_q  <= 1'b0;
    end else if (ram_we) begin
      pin_valid_q[s1_addr] <= 1'b1;
      wb_valid_q           <= 1'b1;
      buf_pin_q            <= buf_pin_d;
      buf_edge_q           <= buf_edge_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      wb_addr_q <= s1_addr;
      wb_data_q <= nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      out_q.event_fired <= s1_act_q && fired;
      out_q.event_pin   <= s1_act_q ? buf_pin_d : buf_pin_q;
      out_q.event_edge  <= s1_act_q ? buf_edge_d : buf_edge_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `ASSERT_HOLDS(a_stall_only_when_full, clk_i, rst_ni,
                in_stall_o |-> (s1_valid_q && out_valid_q))
  `ASSERT_NEVER(a_write_without_advance, clk_i, rst_ni,
                ram_we && !(s1_valid_q && !s1_hold))
  `ASSERT_HOLDS(a_bypass_entry_valid, clk_i, rst_ni,
                wb_valid_q |-> pin_valid_q[wb_addr_q])
  `ASSERT_HOLDS(a_advance_fills_output, clk_i, rst_ni,
                s1_go |=> out_valid_q)

endmodule

[dv/tb.sv]
// Self-checking testbench for multi_pin_edge_debouncer_unit.
// Depends on mpde_pkg and the RTL; a scoreboard class predicts each sample's
// event flag and buffer contents, and plain tasks drive the ports.
`timescale 1ns / 1ps

module tb;
  import mpde_pkg::*;

  // Operation code that the block must ignore; it has no member in op_e.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int         HOLD_CYCLES = 60;

  // Tracks the per-pin lockout timers, last levels and the event buffer, and
  // keeps the results still owed by the block in order of acceptance.
  class debounce_scoreboard;
    logic [7:0] lockout;
    logic [7:0] pin_timer [8];
    logic       pin_level [8];
    logic [2:0] held_pin;
    logic       held_polarity;
    out_t       owed_q [$];
    int         errors;

    function new();
      lockout       = LOCKOUT_RESET;
      held_pin      = '0;
      held_polarity = 1'b0;
      errors        = 0;
      for (int i = 0; i < 8; i++) begin
        pin_timer[i] = '0;
        pin_level[i] = 1'b0;
      end
    endfunction

    function void note_sample(in_t s);
      logic [7:0] t;
      logic       prev;
      logic       trig_hit;
      logic       fired;
      out_t       res;
      t        = pin_timer[s.pin_index];
      prev     = pin_level[s.pin_index];
      trig_hit = (s.level == s.trigger_level) && (prev != s.trigger_level);
      fired    = 1'b0;
      if (s.operation == OP_DC) begin
        // While locked out the pin is not tracked at all.
        if (t != 0) begin
          pin_timer[s.pin_index] = t - 8'd1;
        end else begin
          if (s.level != prev) begin
            fired         = 1'b1;
            held_polarity = s.level;
            held_pin      = s.pin_index;
            pin_timer[s.pin_index] = lockout;
          end
          pin_level[s.pin_index] = s.level;
        end
      end else if (s.operation == OP_AC_NOW || s.operation == OP_AC_END) begin
        if (t != 0) begin
          // The deferred event fires on expiry even when this tick's edge
          // restarts the lockout.
          t = t - 8'd1;
          if (s.operation == OP_AC_END && t == 0) fired = 1'b1;
          if (trig_hit) t = lockout;
          pin_timer[s.pin_index] = t;
        end else if (trig_hit) begin
          pin_timer[s.pin_index] = lockout;
          held_pin = s.pin_index;
          if (s.operation == OP_AC_NOW) fired = 1'b1;
        end
        pin_level[s.pin_index] = s.level;
      end
      res.event_fired = fired;
      res.event_pin   = held_pin;
      res.event_edge  = held_polarity;
      owed_q.push_back(res);
    endfunction

    function void check_result(out_t got);
      out_t exp;
      if (owed_q.size() == 0) begin
        $display("%0t: result %p arrived with none expected", $time, got);
        errors++;
        return;
      end
      exp = owed_q.pop_front();
      if (got.event_fired !== exp.event_fired) begin
        $display("%0t: event_fired expected %0b actual %0b", $time, exp.event_fired,
                 got.event_fired);
        errors++;
      end
      if (got.event_pin !== exp.event_pin) begin
        $display("%0t: event_pin expected %0d actual %0d", $time, exp.event_pin,
                 got.event_pin);
        errors++;
      end
      if (got.event_edge !== exp.event_edge) begin
        $display("%0t: event_edge expected %0b actual %0b", $time, exp.event_edge,
                 got.event_edge);
        errors++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_t        in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_t       out_data;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_data = '0;

  // Set by the stimulus to ask the receiver for one long hold-off.
  bit         long_hold_req = 1'b0;

  debounce_scoreboard sb = new();

  multi_pin_edge_debouncer_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic in_t make_sample(logic [1:0] op, logic [2:0] pin, logic lvl,
                                      logic trig);
    in_t s;
    s.operation     = op;
    s.pin_index     = pin;
    s.level         = lvl;
    s.trigger_level = trig;
    return s;
  endfunction

  // Offers one sample after an optional idle gap and returns at the falling
  // edge after acceptance, with valid still high, so that a following sample
  // can go out without a bubble.
  task automatic send_sample(in_t s, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sb.note_sample(s);
    @(negedge clk_i);
  endtask

  // Stops offering samples and waits until every owed result has come out.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_lockout(logic [7:0] value);
    drain();
    repeat (3) @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk_i);
    cfg_we     <= 1'b0;
    sb.lockout = value;
  endtask

  // Receiver: runs of readiness alternate with stalls. A request for the long
  // hold-off cuts the current run of readiness short, so that the hold-off
  // starts while the stimulus is still sending its burst.
  initial begin
    int ready_len;
    int stall_len;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      ready_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                              : $urandom_range(1, 8);
      out_stall <= 1'b0;
      for (int i = 1; i < ready_len && !long_hold_req; i++) @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_len = HOLD_CYCLES;
      end else begin
        stall_len = pick_gap();
      end
      if (stall_len > 0) begin
        @(negedge clk_i);
        out_stall <= 1'b1;
        repeat (stall_len - 1) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) sb.check_result(out_data);
  end

  initial begin
    logic [7:0] phase_lockout [7];
    logic [1:0] pin_mode [8];
    logic       pin_trig [8];
    logic       drive_lvl [8];
    logic [2:0] hot_a, hot_b, pin;
    logic [1:0] op;
    logic       trig;
    int         count, target, gap, r;

    for (int i = 0; i < 8; i++) drive_lvl[i] = 1'b0;
    phase_lockout = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd6, 8'd2, 8'd0};
    phase_lockout[6] = 8'($urandom_range(1, 12));

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, first with the lockout left at its reset length.
    send_sample(make_sample(OP_DC, 3'd0, 1'b1, 1'b0), pick_gap());     // rising edge
    send_sample(make_sample(OP_DC, 3'd0, 1'b0, 1'b0), pick_gap());     // locked, untracked
    send_sample(make_sample(OP_UNUSED, 3'd6, 1'b1, 1'b1), pick_gap()); // ignored
    send_sample(make_sample(OP_AC_NOW, 3'd7, 1'b1, 1'b1), pick_gap()); // immediate fire
    send_sample(make_sample(OP_AC_NOW, 3'd7, 1'b0, 1'b1), pick_gap());
    send_sample(make_sample(OP_AC_NOW, 3'd7, 1'b1, 1'b1), pick_gap()); // restart in lockout
    write_lockout(8'd2);
    // Deferred trigger: stored now, fires when the lockout runs out.
    send_sample(make_sample(OP_AC_END, 3'd1, 1'b1, 1'b1), pick_gap());
    send_sample(make_sample(OP_AC_END, 3'd1, 1'b1, 1'b1), pick_gap());
    send_sample(make_sample(OP_AC_END, 3'd1, 1'b1, 1'b1), pick_gap());
    // Expiry and a fresh trigger edge on the same tick.
    send_sample(make_sample(OP_AC_END, 3'd2, 1'b1, 1'b1), pick_gap());
    send_sample(make_sample(OP_AC_END, 3'd2, 1'b0, 1'b1), pick_gap());
    send_sample(make_sample(OP_AC_END, 3'd2, 1'b1, 1'b1), pick_gap());
    // DC rising edge, lockout, then the falling edge once it has run out.
    send_sample(make_sample(OP_DC, 3'd4, 1'b1, 1'b1), pick_gap());
    send_sample(make_sample(OP_DC, 3'd4, 1'b0, 1'b1), pick_gap());
    send_sample(make_sample(OP_DC, 3'd4, 1'b0, 1'b1), pick_gap());
    send_sample(make_sample(OP_DC, 3'd4, 1'b0, 1'b1), pick_gap());
    // Falling trigger level in the immediate mode.
    send_sample(make_sample(OP_AC_NOW, 3'd5, 1'b0, 1'b0), pick_gap());
    send_sample(make_sample(OP_AC_NOW, 3'd5, 1'b1, 1'b0), pick_gap());
    send_sample(make_sample(OP_AC_NOW, 3'd5, 1'b0, 1'b0), pick_gap());
    // A lockout of zero turns debouncing off.
    write_lockout(8'd0);
    send_sample(make_sample(OP_DC, 3'd3, 1'b1, 1'b0), pick_gap());
    send_sample(make_sample(OP_DC, 3'd3, 1'b0, 1'b0), pick_gap());
    send_sample(make_sample(OP_AC_END, 3'd6, 1'b1, 1'b1), pick_gap());
    send_sample(make_sample(OP_UNUSED, 3'd0, 1'b0, 1'b0), pick_gap());

    // Random phases. Each phase gives every pin a preferred mode and trigger
    // level and concentrates on two busy pins, so that lockouts run their
    // course and the deferred events are reached; the rest is noise.
    for (int ph = 0; ph < 7; ph++) begin
      write_lockout(phase_lockout[ph]);
      for (int i = 0; i < 8; i++) begin
        pin_mode[i] = 2'($urandom_range(0, 2));
        pin_trig[i] = 1'($urandom_range(0, 1));
      end
      hot_a  = 3'($urandom_range(0, 7));
      hot_b  = 3'($urandom_range(0, 7));
      target = (phase_lockout[ph] == 8'd255) ? 60 : 115;
      count  = 0;
      while (count < target) begin
        if (ph == 1 && count == 20) long_hold_req = 1'b1;
        if (ph == 3 && count == 40) drain();
        r   = $urandom_range(0, 9);
        pin = (r < 4) ? hot_a : (r < 7) ? hot_b : 3'($urandom_range(0, 7));
        r   = $urandom_range(0, 99);
        op  = (r < 80) ? pin_mode[pin] : (r < 95) ? 2'($urandom_range(0, 2)) : OP_UNUSED;
        trig = ($urandom_range(0, 6) == 0) ? 1'($urandom_range(0, 1)) : pin_trig[pin];
        if ($urandom_range(0, 9) < 4) drive_lvl[pin] = ~drive_lvl[pin];
        // Back-to-back bursts, and a full one while the receiver holds off.
        gap = ((count % 64) < 20 || (ph == 1 && count >= 20 && count < 40)) ? 0
                                                                             : pick_gap();
        send_sample(make_sample(op, pin, drive_lvl[pin], trig), gap);
        if (op != OP_UNUSED) count++;
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** multi_pin_edge_debouncer_unit: PASSED **");
    end else begin
      $display("** multi_pin_edge_debouncer_unit: FAILED **");
    end
    $finish;
  end

  // Far beyond the slowest correct run, allowing for every gap and stall.
  initial begin
    #2_000_000;
    $display("%0t: timed out with %0d results owed", $time, sb.pending());
    $display("** multi_pin_edge_debouncer_unit: FAILED **");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/mpde_pkg.sv
hdl/mpde_ram.sv
hdl/multi_pin_edge_debouncer_unit.sv
dv/tb.sv
